@@ hw/rtl/pcint_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcint_pkg
// Shared constants, codes and control structs of the step-function integrator.
// ----------------------------------------------------------------------------
package pcint_pkg;

    localparam int MAX_BREAKPOINTS = 16;
    localparam int BP_IDX_W  = $clog2(MAX_BREAKPOINTS);
    localparam int LVL_IDX_W = $clog2(MAX_BREAKPOINTS + 1);
    localparam int SEG_W     = $clog2(MAX_BREAKPOINTS + 1);
    localparam int CNT_W     = 5;
    localparam int SQ_W      = 104;   // sum of squared levels times durations, Q72.32
    localparam int NUM_W     = 88;    // divider numerator width
    localparam int LEN_W     = 33;
    localparam int DIV_CNT_W = 7;

    typedef enum logic [1:0] {
        MODE_WR_BP  = 2'd0,
        MODE_WR_LVL = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_WR_ACK   = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    localparam logic [2:0] REG_BP_COUNT = 3'd0;

    typedef struct packed {
        logic             accept;
        logic             seg_rd;
        logic             seg_clip;
        logic             seg_mul;
        logic             seg_mlo;
        logic             seg_mhi;
        logic             seg_acc;
        logic             div_load_mean;
        logic             div_load_msq;
        logic             div_step;
        logic             save_mean;
        logic             load_out;
        logic [SEG_W-1:0] seg_idx;
    } t_cmd;

    typedef struct packed {
        logic             in_valid;
        logic             in_run;
        logic             out_busy;
        logic [SEG_W-1:0] seg_last;
    } t_stat;

endpackage

@@ hw/rtl/pcint_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcint_ctrl
// Sequencer: segment walk, two divider passes, result hand-off.
// ----------------------------------------------------------------------------
module pcint_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcint_pkg::t_stat i_stat,
    output pcint_pkg::t_cmd  o_cmd,
    output logic             o_in_ready
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_RD       = 12'b000000000010,
        S_CLIP     = 12'b000000000100,
        S_MUL      = 12'b000000001000,
        S_MLO      = 12'b000000010000,
        S_MHI      = 12'b000000100000,
        S_ACC      = 12'b000001000000,
        S_LD_MEAN  = 12'b000010000000,
        S_DIV_MEAN = 12'b000100000000,
        S_SAVE     = 12'b001000000000,
        S_DIV_MSQ  = 12'b010000000000,
        S_FINISH   = 12'b100000000000
    } t_state;

    t_state                          r_state, n_state;
    logic [pcint_pkg::SEG_W-1:0]     r_seg, n_seg;
    logic [pcint_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.seg_idx = r_seg;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_seg = '0;
                    n_state = i_stat.in_run ? S_RD : S_FINISH;
                end
            end
            S_RD: begin
                o_cmd.seg_rd = 1'b1;
                n_state = S_CLIP;
            end
            S_CLIP: begin
                o_cmd.seg_clip = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.seg_mul = 1'b1;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.seg_mlo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.seg_mhi = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.seg_acc = 1'b1;
                if (r_seg == i_stat.seg_last) begin
                    n_state = S_LD_MEAN;
                end else begin
                    n_seg = r_seg + 1'b1;
                    n_state = S_RD;
                end
            end
            S_LD_MEAN: begin
                o_cmd.div_load_mean = 1'b1;
                n_cnt = pcint_pkg::DIV_CNT_W'(pcint_pkg::NUM_W);
                n_state = S_DIV_MEAN;
            end
            S_DIV_MEAN: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    n_state = S_SAVE;
                end
            end
            S_SAVE: begin
                o_cmd.save_mean = 1'b1;
                o_cmd.div_load_msq = 1'b1;
                n_cnt = pcint_pkg::DIV_CNT_W'(pcint_pkg::NUM_W);
                n_state = S_DIV_MSQ;
            end
            S_DIV_MSQ: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_seg <= i_stat.seg_last)) else $error("segment overrun");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_stat.out_busy) |=> (r_state == S_IDLE))
        else $error("result not handed off");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_MEAN || r_state == S_DIV_MSQ) |-> (r_cnt != 0))
        else $error("divider count empty");

endmodule

@@ hw/rtl/pcint_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcint_dp
// Tables, segment clip and multiply-accumulate, radix-2 divider, result register.
// ----------------------------------------------------------------------------
module pcint_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcint_pkg::t_cmd           i_cmd,
    output pcint_pkg::t_stat          o_stat,
    input  logic [pcint_pkg::CNT_W-1:0] i_bp_count,
    input  logic                      i_in_valid,
    input  logic [1:0]                i_mode,
    input  logic [4:0]                i_entry_index,
    input  logic signed [31:0]        i_entry_value,
    input  logic signed [31:0]        i_time_start,
    input  logic signed [31:0]        i_time_end,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [63:0]        o_integral_value,
    output logic [62:0]               o_integral_square_value,
    output logic signed [63:0]        o_mean_value,
    output logic [62:0]               o_mean_square_value,
    output logic [1:0]                o_status
);

    localparam int SQ_W  = pcint_pkg::SQ_W;
    localparam int NUM_W = pcint_pkg::NUM_W;
    localparam int LEN_W = pcint_pkg::LEN_W;

    logic [31:0] r_bp_mem  [pcint_pkg::MAX_BREAKPOINTS];
    logic [31:0] r_lvl_mem [pcint_pkg::MAX_BREAKPOINTS + 1];

    logic [1:0]            r_mode;
    logic                  r_run;
    logic signed [31:0]    r_ts, r_te;
    logic [LEN_W-1:0]      r_len;
    logic [pcint_pkg::SEG_W-1:0] r_n;
    logic signed [31:0]    r_bpa, r_bpb, r_lvl;
    logic                  r_on;
    logic [LEN_W-1:0]      r_dt;
    logic signed [63:0]    r_pl;
    logic [63:0]           r_s;
    logic [64:0]           r_pp;
    logic signed [63:0]    r_acc;
    logic [SQ_W-1:0]       r_sq;
    logic [NUM_W-1:0]      r_num, r_q;
    logic [LEN_W-1:0]      r_rem;
    logic signed [63:0]    r_mean;
    logic                  r_out_valid;

    logic                  in_run;
    logic [pcint_pkg::SEG_W-1:0] n_sat;
    logic signed [31:0]    lo, hi;
    logic [31:0]           lvl_mag;
    logic signed [64:0]    acc_sum;
    logic [63:0]           acc_mag, int_mag;
    logic [LEN_W:0]        rem2;
    logic                  qbit;

    assign in_run = (pcint_pkg::t_mode'(i_mode) == pcint_pkg::MODE_QUERY)
                    && (i_time_end > i_time_start);
    assign n_sat  = (i_bp_count > pcint_pkg::CNT_W'(pcint_pkg::MAX_BREAKPOINTS))
                    ? pcint_pkg::SEG_W'(pcint_pkg::MAX_BREAKPOINTS)
                    : pcint_pkg::SEG_W'(i_bp_count);

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.in_run   = in_run;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_stat.seg_last = r_n;

    // table writes and per-segment reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && pcint_pkg::t_mode'(i_mode) == pcint_pkg::MODE_WR_BP
            && i_entry_index < 5'(pcint_pkg::MAX_BREAKPOINTS)) begin
            r_bp_mem[i_entry_index[pcint_pkg::BP_IDX_W-1:0]] <= i_entry_value;
        end
        if (i_cmd.accept && pcint_pkg::t_mode'(i_mode) == pcint_pkg::MODE_WR_LVL
            && i_entry_index <= 5'(pcint_pkg::MAX_BREAKPOINTS)) begin
            r_lvl_mem[i_entry_index[pcint_pkg::LVL_IDX_W-1:0]] <= i_entry_value;
        end
        if (i_cmd.seg_rd) begin
            r_bpa <= r_bp_mem[pcint_pkg::BP_IDX_W'(i_cmd.seg_idx - 1'b1)];
            r_bpb <= r_bp_mem[i_cmd.seg_idx[pcint_pkg::BP_IDX_W-1:0]];
            r_lvl <= r_lvl_mem[pcint_pkg::LVL_IDX_W'(i_cmd.seg_idx)];
        end
    end

    always_comb begin
        lo = r_ts;
        hi = r_te;
        if (i_cmd.seg_idx != 0 && r_bpa > lo) begin
            lo = r_bpa;
        end
        if (i_cmd.seg_idx != r_n && r_bpb < hi) begin
            hi = r_bpb;
        end
    end

    assign lvl_mag = r_lvl[31] ? 32'(-r_lvl) : 32'(r_lvl);
    assign acc_sum = 65'(r_acc) + 65'(r_pl);
    assign acc_mag = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign int_mag = acc_mag >> 16;
    assign rem2    = {r_rem, r_num[NUM_W-1]};
    assign qbit    = (rem2 >= {1'b0, r_len});

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_run  <= in_run;
            r_ts   <= i_time_start;
            r_te   <= i_time_end;
            r_len  <= LEN_W'(33'(i_time_end) - 33'(i_time_start));
            r_n    <= n_sat;
            r_acc  <= '0;
            r_sq   <= '0;
        end
        if (i_cmd.seg_clip) begin
            r_on <= (hi > lo);
            r_dt <= LEN_W'(33'(hi) - 33'(lo));
        end
        if (i_cmd.seg_mul) begin
            r_pl <= 64'(66'(r_lvl) * 66'($signed({1'b0, r_dt})));
            r_s  <= 64'(lvl_mag) * 64'(lvl_mag);
        end
        if (i_cmd.seg_mlo) begin
            r_pp <= 65'(r_s[31:0]) * 65'(r_dt);
        end
        if (i_cmd.seg_mhi) begin
            if (r_on) begin
                r_sq <= r_sq + SQ_W'(r_pp);
            end
            r_pp <= 65'(r_s[63:32]) * 65'(r_dt);
        end
        if (i_cmd.seg_acc && r_on) begin
            r_sq <= r_sq + (SQ_W'(r_pp) << 32);
            if (acc_sum[64] != acc_sum[63]) begin
                r_acc <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                r_acc <= acc_sum[63:0];
            end
        end
        if (i_cmd.div_load_mean) begin
            r_num <= NUM_W'(acc_mag);
            r_rem <= '0;
            r_q   <= '0;
        end
        if (i_cmd.div_load_msq) begin
            r_num <= r_sq[SQ_W-1:16];
            r_rem <= '0;
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_q   <= {r_q[NUM_W-2:0], qbit};
            r_rem <= qbit ? LEN_W'(rem2 - {1'b0, r_len}) : rem2[LEN_W-1:0];
        end
        if (i_cmd.save_mean) begin
            r_mean <= r_acc[63] ? 64'(-r_q[63:0]) : r_q[63:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_integral_value        <= '0;
            o_integral_square_value <= '0;
            o_mean_value            <= '0;
            o_mean_square_value     <= '0;
            if (pcint_pkg::t_mode'(r_mode) != pcint_pkg::MODE_QUERY) begin
                o_status <= pcint_pkg::ST_WR_ACK;
            end else if (!r_run) begin
                o_status <= pcint_pkg::ST_EMPTY;
            end else begin
                o_status <= pcint_pkg::ST_OK;
                o_integral_value <= r_acc[63] ? 64'(-int_mag) : int_mag;
                o_integral_square_value <= (r_sq[SQ_W-1:95] != 0) ? {63{1'b1}}
                                                                  : r_sq[94:32];
                o_mean_value <= r_mean;
                o_mean_square_value <= (r_q[NUM_W-1:63] != 0) ? {63{1'b1}} : r_q[62:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/piecewise_constant_integrator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_constant_integrator_top
// Step-function table with interval integral, square integral and means.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser mode, tdata entry/time fields
//  m_axis    out  tvalid/tready          tuser status, tdata four results
//  apb       in   psel/penable/pwrite    breakpoint_count at byte 0
//
//  A write or unused-mode word goes from idle through the finish state to the result register.
//  A query walks n+1 segments, n the saturated breakpoint count, six steps
//  per segment through the shared multiplier, then one radix-2 divider run
//  twice (mean, then mean square), one quotient bit a cycle.
//  One word is in work at a time; the next is taken once the previous has
//  reached the result register, which holds under m_axis_tready low.
//  Reset clears the sequencer, count register and result valid; tables are
//  not cleared.
// ----------------------------------------------------------------------------
module piecewise_constant_integrator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [4:0] entry_index, [36:5] entry_value, [68:37] time_start,
    // [100:69] time_end, [103:101] zero
    input  logic [103:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] integral_value, [126:64] integral_square_value,
    // [190:127] mean_value, [253:191] mean_square_value, [255:254] zero
    output logic [255:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    pcint_pkg::t_cmd  cmd;
    pcint_pkg::t_stat stat;
    logic             in_ready;
    logic [pcint_pkg::CNT_W-1:0] r_bp_count;

    logic signed [63:0] integral_value, mean_value;
    logic [62:0]        integral_square_value, mean_square_value;

    // configuration register: to be written only while idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_count <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == pcint_pkg::REG_BP_COUNT) begin
            r_bp_count <= pwdata[pcint_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == pcint_pkg::REG_BP_COUNT) ? 32'(r_bp_count) : 32'd0;

    pcint_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    pcint_dp u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .o_stat                  (stat),
        .i_bp_count              (r_bp_count),
        .i_in_valid              (s_axis_tvalid),
        .i_mode                  (s_axis_tuser),
        .i_entry_index           (s_axis_tdata[4:0]),
        .i_entry_value           (s_axis_tdata[36:5]),
        .i_time_start            (s_axis_tdata[68:37]),
        .i_time_end              (s_axis_tdata[100:69]),
        .i_out_ready             (m_axis_tready),
        .o_out_valid             (m_axis_tvalid),
        .o_integral_value        (integral_value),
        .o_integral_square_value (integral_square_value),
        .o_mean_value            (mean_value),
        .o_mean_square_value     (mean_square_value),
        .o_status                (m_axis_tuser)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {2'b00, mean_square_value, mean_value,
                            integral_square_value, integral_value};

endmodule
